// ===== hw/rtl/cbve_pkg.sv =====
`default_nettype none

package cbve_pkg;

  // Number of entries in one codebook.
  localparam int BOOK_ENTRIES = 256;
  // Entry counter must be able to hold BOOK_ENTRIES itself.
  localparam int ENTRY_W = $clog2(BOOK_ENTRIES + 1);

  // Depth of the vector queue between the parser and the pixel expander.
  localparam int JOB_Q_DEPTH = 4;
  localparam int JOB_Q_PTR_W = $clog2(JOB_Q_DEPTH);
  localparam int JOB_Q_CNT_W = $clog2(JOB_Q_DEPTH + 1);

  // Atom type codes. Bit 0 selects a partial book, bit 1 the smooth book.
  localparam logic [7:0] TYPE_FULL_DETAIL  = 8'h20;
  localparam logic [7:0] TYPE_PART_DETAIL  = 8'h21;
  localparam logic [7:0] TYPE_FULL_SMOOTH  = 8'h22;
  localparam logic [7:0] TYPE_PART_SMOOTH  = 8'h23;

  // One complete codebook vector, ready to be expanded into four pixels.
  typedef struct packed {
    logic [7:0]      entry;
    logic            book;
    logic [3:0][7:0] y;
    logic [7:0]      u;
    logic [7:0]      v;
  } job_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cbve_front.sv =====
`default_nettype none

module cbve_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [7:0]      data_byte,
  input  wire logic            atom_start,
  input  wire logic            accept,
  output logic                 walking,
  output logic                 q_push,
  output cbve_pkg::job_t       q_job
);

  typedef enum logic [6:0] {
    PH_IDLE = 7'b0000001,
    PH_SIZE = 7'b0000010,
    PH_FULL = 7'b0000100,
    PH_MASK = 7'b0001000,
    PH_WALK = 7'b0010000,
    PH_PVEC = 7'b0100000,
    PH_DONE = 7'b1000000
  } phase_t;

  localparam int EW = cbve_pkg::ENTRY_W;

  phase_t          phase_r, phase_nxt;
  logic [1:0]      hc_r, hc_nxt;
  logic [7:0]      type_r, type_nxt;
  logic [23:0]     vl_r, vl_nxt;
  logic [EW-1:0]   entry_r, entry_nxt;
  logic [31:0]     mask_r, mask_nxt;
  logic [5:0]      bits_r, bits_nxt;
  logic [2:0]      vbc_r, vbc_nxt;
  logic [7:0]      vb_r [5];
  logic            vb_we;

  logic [23:0]     size_w;
  logic [23:0]     rem_after;
  logic [EW-1:0]   room;
  logic [3:0]      lim;
  logic [3:0]      skip;
  logic            found;
  logic            type_ok;

  // Scan of up to eight mask bits per cycle for the next coded entry.
  always_comb begin
    room = EW'(cbve_pkg::BOOK_ENTRIES) - entry_r;
    lim  = 4'd8;
    if (bits_r < 6'd8) lim = 4'(bits_r);
    if (room < EW'(lim)) lim = 4'(room);
    found = 1'b0;
    skip  = lim;
    for (int i = 7; i >= 0; i--) begin
      if ((4'(i) < lim) && mask_r[31 - i]) begin
        found = 1'b1;
        skip  = 4'(i);
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    hc_nxt    = hc_r;
    type_nxt  = type_r;
    vl_nxt    = vl_r;
    entry_nxt = entry_r;
    mask_nxt  = mask_r;
    bits_nxt  = bits_r;
    vbc_nxt   = vbc_r;
    vb_we     = 1'b0;
    q_push    = 1'b0;
    size_w    = {vl_r[15:0], data_byte};
    rem_after = vl_r - 24'd6;
    type_ok   = (data_byte == cbve_pkg::TYPE_FULL_DETAIL) ||
                (data_byte == cbve_pkg::TYPE_PART_DETAIL) ||
                (data_byte == cbve_pkg::TYPE_FULL_SMOOTH) ||
                (data_byte == cbve_pkg::TYPE_PART_SMOOTH);

    if (phase_r == PH_WALK) begin
      if (entry_r >= EW'(cbve_pkg::BOOK_ENTRIES)) begin
        phase_nxt = PH_DONE;
      end else if (bits_r == 6'd0) begin
        phase_nxt = PH_MASK;
        vbc_nxt   = 3'd0;
        mask_nxt  = 32'd0;
      end else begin
        mask_nxt  = mask_r << skip;
        entry_nxt = entry_r + EW'(skip);
        bits_nxt  = bits_r - 6'(skip);
        if (found) begin
          phase_nxt = PH_PVEC;
          vbc_nxt   = 3'd0;
        end
      end
    end else if (accept && atom_start) begin
      type_nxt  = data_byte;
      hc_nxt    = 2'd0;
      vl_nxt    = 24'd0;
      phase_nxt = type_ok ? PH_SIZE : PH_DONE;
    end else if (accept) begin
      unique case (phase_r)
        PH_SIZE: begin
          vl_nxt = size_w;
          hc_nxt = hc_r + 2'd1;
          if (hc_r == 2'd2) begin
            hc_nxt    = 2'd0;
            entry_nxt = '0;
            vbc_nxt   = 3'd0;
            bits_nxt  = 6'd0;
            mask_nxt  = 32'd0;
            if (size_w == 24'd4) begin
              vl_nxt    = 24'd0;
              phase_nxt = PH_DONE;
            end else if (!type_r[0]) begin
              // Bytes after the header; a vector needs six of them.
              vl_nxt    = size_w - 24'd4;
              phase_nxt = (size_w >= 24'd10) ? PH_FULL : PH_DONE;
            end else begin
              vl_nxt    = 24'd0;
              phase_nxt = PH_MASK;
            end
          end
        end
        PH_FULL, PH_PVEC: begin
          if (vbc_r < 3'd5) begin
            vb_we   = 1'b1;
            vbc_nxt = vbc_r + 3'd1;
          end else begin
            q_push    = 1'b1;
            vbc_nxt   = 3'd0;
            entry_nxt = entry_r + EW'(1);
            if (phase_r == PH_FULL) begin
              vl_nxt = rem_after;
              if ((rem_after < 24'd6) ||
                  (entry_r == EW'(cbve_pkg::BOOK_ENTRIES - 1))) begin
                phase_nxt = PH_DONE;
              end
            end else begin
              mask_nxt  = mask_r << 1;
              bits_nxt  = bits_r - 6'd1;
              phase_nxt = PH_WALK;
            end
          end
        end
        PH_MASK: begin
          mask_nxt = {mask_r[23:0], data_byte};
          vbc_nxt  = vbc_r + 3'd1;
          if (vbc_r == 3'd3) begin
            vbc_nxt   = 3'd0;
            bits_nxt  = 6'd32;
            phase_nxt = PH_WALK;
          end
        end
        PH_IDLE, PH_DONE, PH_WALK: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hc_r    <= 2'd0;
      type_r  <= 8'd0;
      vl_r    <= 24'd0;
      entry_r <= '0;
      mask_r  <= 32'd0;
      bits_r  <= 6'd0;
      vbc_r   <= 3'd0;
    end else begin
      phase_r <= phase_nxt;
      hc_r    <= hc_nxt;
      type_r  <= type_nxt;
      vl_r    <= vl_nxt;
      entry_r <= entry_nxt;
      mask_r  <= mask_nxt;
      bits_r  <= bits_nxt;
      vbc_r   <= vbc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (vb_we) begin
      vb_r[vbc_r] <= data_byte;
    end
  end

  always_comb begin
    q_job.entry = 8'(entry_r);
    q_job.book  = type_r[1];
    for (int i = 0; i < 4; i++) begin
      q_job.y[i] = vb_r[i];
    end
    q_job.u = vb_r[4];
    q_job.v = data_byte;
  end

  assign walking = (phase_r == PH_WALK);

`ifndef SYNTHESIS
  a_entry_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_r <= EW'(cbve_pkg::BOOK_ENTRIES))
    else $error("entry counter ran past the end of the book");

  a_push_sixth: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (vbc_r == 3'd5 && (phase_r == PH_FULL || phase_r == PH_PVEC)))
    else $error("vector pushed before all six bytes were collected");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/cbve_fifo.sv =====
`default_nettype none

module cbve_fifo (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire cbve_pkg::job_t  wr_data,
  output logic                 full,
  input  wire logic            pop,
  output cbve_pkg::job_t       rd_data,
  output logic                 empty
);

  localparam int PW = cbve_pkg::JOB_Q_PTR_W;
  localparam int CW = cbve_pkg::JOB_Q_CNT_W;

  cbve_pkg::job_t  mem [cbve_pkg::JOB_Q_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            wr_en, rd_en;

  assign full    = (count_r == CW'(cbve_pkg::JOB_Q_DEPTH));
  assign empty   = (count_r == '0);
  assign wr_en   = push && !full;
  assign rd_en   = pop && !empty;
  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (rd_en) rd_ptr_r <= rd_ptr_r + PW'(1);
      unique case ({wr_en, rd_en})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(cbve_pkg::JOB_Q_DEPTH))
    else $error("vector queue occupancy exceeds its depth");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/cbve_back.sv =====
`default_nettype none

module cbve_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            job_valid,
  input  wire cbve_pkg::job_t  job,
  output logic                 job_pop,
  output logic [7:0]           entry_index,
  output logic                 book_select,
  output logic [1:0]           pixel_pos,
  output logic [7:0]           chan_y_plus_u,
  output logic [7:0]           chan_y_minus_uv,
  output logic [7:0]           chan_y_plus_v,
  output logic                 last_pixel,
  output logic                 empty,
  input  wire logic            pop
);

  logic              out_valid_r;
  logic [1:0]        pix_r;
  logic [7:0]        entry_r, blue_r, green_r, red_r;
  logic              book_r, last_r;
  logic [1:0]        pos_r;

  logic              fire;
  logic signed [10:0] y_s, u2_s, v_s, v2_s, uv_s, blue_s, green_s, red_s;

  function automatic logic [7:0] clip8(input logic signed [10:0] x);
    if (x[10]) begin
      return 8'd0;
    end else if (x[9:8] != 2'b00) begin
      return 8'hFF;
    end else begin
      return x[7:0];
    end
  endfunction

  // Chroma terms are signed bytes; green uses floor((V + 2U) / 2).
  always_comb begin
    y_s     = {3'b000, job.y[pix_r]};
    u2_s    = {{2{job.u[7]}}, job.u, 1'b0};
    v_s     = {{3{job.v[7]}}, job.v};
    v2_s    = {{2{job.v[7]}}, job.v, 1'b0};
    uv_s    = (v_s + u2_s) >>> 1;
    blue_s  = y_s + u2_s;
    green_s = y_s - uv_s;
    red_s   = y_s + v2_s;
  end

  assign fire    = job_valid && (!out_valid_r || pop);
  assign job_pop = fire && (pix_r == 2'd3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pix_r       <= 2'd0;
    end else begin
      if (fire) begin
        out_valid_r <= 1'b1;
        pix_r       <= pix_r + 2'd1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      entry_r <= job.entry;
      book_r  <= job.book;
      pos_r   <= pix_r;
      blue_r  <= clip8(blue_s);
      green_r <= clip8(green_s);
      red_r   <= clip8(red_s);
      last_r  <= (pix_r == 2'd3);
    end
  end

  assign empty           = !out_valid_r;
  assign entry_index     = entry_r;
  assign book_select     = book_r;
  assign pixel_pos       = pos_r;
  assign chan_y_plus_u   = blue_r;
  assign chan_y_minus_uv = green_r;
  assign chan_y_plus_v   = red_r;
  assign last_pixel      = last_r;

`ifndef SYNTHESIS
  a_last_matches_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (last_r == (pos_r == 2'd3)))
    else $error("last pixel flag disagrees with pixel position");

  a_restart_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> (pix_r == 2'd0))
    else $error("pixel counter did not wrap after a vector finished");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/codebook_vector_expander_top.sv =====
// Codebook vector expander.
// The input channel takes the bytes of one codebook atom, one per transaction,
// with in_atom_start high on the type byte. A transaction completes on a rising
// edge with push high and full low. Full books and partial books (a 32-bit
// mask word before each group of 32 entries) are parsed, and every complete
// six-byte vector is expanded into four clipped pixels (blue, green, red).
// The result channel looks like a queue: while empty is low the oldest pixel
// is on the out_ ports, and pop with empty low completes the transaction.
// Pixel 0 of a vector passes the vector queue and the output register after its
// sixth byte is taken; the other three follow one per cycle while the receiver
// pops. Bytes are taken one per cycle in full books while the queue has room.
// In partial books the mask scan looks at up to eight mask bits per cycle, so
// full is high after each mask word and after each coded vector while it runs.
// A four-entry vector queue decouples the byte parser from the pixel stage,
// so a stalled receiver only blocks input once that queue fills; full then
// stays high until the head vector is expanded. No result is lost or repeated.
// A synchronous active-low reset returns the parser to idle and empties the
// queue and the output register; nothing needs to be cleared afterwards.
`default_nettype none

module codebook_vector_expander_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_atom_start,
  input  wire logic        push,
  output logic             full,
  output logic [7:0]       out_entry_index,
  output logic             out_book_select,
  output logic [1:0]       out_pixel_pos,
  output logic [7:0]       out_chan_y_plus_u,
  output logic [7:0]       out_chan_y_minus_uv,
  output logic [7:0]       out_chan_y_plus_v,
  output logic             out_last_pixel,
  output logic             empty,
  input  wire logic        pop
);

  // Handshake between the parser and the vector queue.
  logic            walking;
  logic            accept;
  logic            q_push;
  logic            q_full;
  cbve_pkg::job_t  q_wr_job;

  // Handshake between the vector queue and the pixel stage.
  logic            q_empty;
  logic            q_pop;
  cbve_pkg::job_t  q_rd_job;

  // The parser stalls input while it scans the mask, or when the queue
  // could not take a finished vector.
  assign full   = q_full || walking;
  assign accept = push && !full;

  cbve_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .data_byte  (in_data_byte),
    .atom_start (in_atom_start),
    .accept     (accept),
    .walking    (walking),
    .q_push     (q_push),
    .q_job      (q_wr_job)
  );

  cbve_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_job),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_job),
    .empty   (q_empty)
  );

  // The pixel stage emits one pixel per cycle from the head of the queue
  // and holds its output register while the receiver stalls.
  cbve_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (!q_empty),
    .job             (q_rd_job),
    .job_pop         (q_pop),
    .entry_index     (out_entry_index),
    .book_select     (out_book_select),
    .pixel_pos       (out_pixel_pos),
    .chan_y_plus_u   (out_chan_y_plus_u),
    .chan_y_minus_uv (out_chan_y_minus_uv),
    .chan_y_plus_v   (out_chan_y_plus_v),
    .last_pixel      (out_last_pixel),
    .empty           (empty),
    .pop             (pop)
  );

endmodule

`default_nettype wire

// ===== verif/codebook_vector_expander_checker.sv =====
module codebook_vector_expander_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_data_byte,
  input  logic       in_atom_start,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] out_entry_index,
  input  logic       out_book_select,
  input  logic [1:0] out_pixel_pos,
  input  logic [7:0] out_chan_y_plus_u,
  input  logic [7:0] out_chan_y_minus_uv,
  input  logic [7:0] out_chan_y_plus_v,
  input  logic       out_last_pixel,
  input  logic       empty,
  input  logic       pop,
  output int         fail_total,
  output int         pending,
  output int         bytes_used,
  output int         pixels_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [5:0] {
    PARSE_IDLE = 6'b000001,
    PARSE_SIZE = 6'b000010,
    PARSE_FULL = 6'b000100,
    PARSE_MASK = 6'b001000,
    PARSE_VEC  = 6'b010000,
    PARSE_DONE = 6'b100000
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] entry;
    logic       book;
    logic [1:0] pos;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last;
  } pixel_t;

  parse_phase_t phase;
  logic [1:0]   hdr_cnt;
  logic [7:0]   atom_code;
  logic [23:0]  vec_left;
  logic [8:0]   entry_cnt;
  logic [31:0]  mask_q;
  logic [5:0]   mask_left;
  logic [7:0]   vec_bytes [5];
  logic [2:0]   byte_cnt;

  pixel_t pending_pixels [$];
  int     mism_cnt    = 0;
  int     used_cnt    = 0;
  int     checked_cnt = 0;

  function automatic logic [7:0] clamp_pixel(input int x);
    if (x < 0) return 8'h00;
    if (x > 255) return 8'hFF;
    return 8'(x);
  endfunction

  task automatic report_mismatch(input string what);
    mism_cnt++;
    $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Skip clear mask bits until a coded entry, a new mask word or the end of the book.
  task automatic scan_mask();
    while (entry_cnt < cbve_pkg::BOOK_ENTRIES) begin
      if (mask_left == 0) begin
        phase    = PARSE_MASK;
        byte_cnt = 0;
        mask_q   = 0;
        return;
      end
      if (mask_q[31]) begin
        phase    = PARSE_VEC;
        byte_cnt = 0;
        return;
      end
      mask_q    = mask_q << 1;
      mask_left = mask_left - 1;
      entry_cnt = entry_cnt + 1;
    end
    phase = PARSE_DONE;
  endtask

  // The sixth byte (V) completes the vector: queue its four pixels.
  task automatic expand_vector(input logic [7:0] v_byte);
    int     u2;
    int     v_s;
    int     uv_half;
    int     y;
    int     i;
    pixel_t px;
    u2      = 2 * int'($signed(vec_bytes[4]));
    v_s     = int'($signed(v_byte));
    // Floor of (V + 2U) / 2, kept positive before the shift.
    uv_half = ((v_s + u2 + 512) >> 1) - 256;
    for (i = 0; i < 4; i++) begin
      y        = int'(vec_bytes[i]);
      px.entry = entry_cnt[7:0];
      px.book  = atom_code[1];
      px.pos   = 2'(i);
      px.blue  = clamp_pixel(y + u2);
      px.green = clamp_pixel(y - uv_half);
      px.red   = clamp_pixel(y + 2 * v_s);
      px.last  = (i == 3);
      pending_pixels.push_back(px);
    end
  endtask

  task automatic parse_atom_byte(input logic [7:0] d, input logic first);
    logic [23:0] size;
    int          n;
    if (first) begin
      atom_code = d;
      hdr_cnt   = 0;
      vec_left  = 0;
      phase     = (d >= cbve_pkg::TYPE_FULL_DETAIL && d <= cbve_pkg::TYPE_PART_SMOOTH) ?
                  PARSE_SIZE : PARSE_DONE;
      return;
    end
    case (phase)
      PARSE_SIZE: begin
        vec_left = {vec_left[15:0], d};
        hdr_cnt  = hdr_cnt + 1;
        if (hdr_cnt == 3) begin
          hdr_cnt   = 0;
          size      = vec_left;
          entry_cnt = 0;
          byte_cnt  = 0;
          mask_left = 0;
          mask_q    = 0;
          if (size == 24'd4) begin
            vec_left = 0;
            phase    = PARSE_DONE;
          end else if (!atom_code[0]) begin
            n = (size > 24'd4) ? int'((size - 24'd4) / 24'd6) : 0;
            if (n > cbve_pkg::BOOK_ENTRIES) n = cbve_pkg::BOOK_ENTRIES;
            vec_left = 24'(n);
            phase    = (n == 0) ? PARSE_DONE : PARSE_FULL;
          end else begin
            vec_left = 0;
            scan_mask();
          end
        end
      end
      PARSE_FULL: begin
        if (byte_cnt < 5) begin
          vec_bytes[byte_cnt] = d;
          byte_cnt            = byte_cnt + 1;
        end else begin
          expand_vector(d);
          byte_cnt  = 0;
          entry_cnt = entry_cnt + 1;
          vec_left  = vec_left - 1;
          if (vec_left == 0) phase = PARSE_DONE;
        end
      end
      PARSE_MASK: begin
        mask_q   = {mask_q[23:0], d};
        byte_cnt = byte_cnt + 1;
        if (byte_cnt >= 4) begin
          byte_cnt  = 0;
          mask_left = 6'd32;
          scan_mask();
        end
      end
      PARSE_VEC: begin
        if (byte_cnt < 5) begin
          vec_bytes[byte_cnt] = d;
          byte_cnt            = byte_cnt + 1;
        end else begin
          expand_vector(d);
          byte_cnt  = 0;
          mask_q    = mask_q << 1;
          mask_left = mask_left - 1;
          entry_cnt = entry_cnt + 1;
          scan_mask();
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    pixel_t got_px;
    pixel_t exp_px;
    if (!rst_n) begin
      phase     = PARSE_IDLE;
      hdr_cnt   = 0;
      atom_code = 0;
      vec_left  = 0;
      entry_cnt = 0;
      mask_q    = 0;
      mask_left = 0;
      byte_cnt  = 0;
      foreach (vec_bytes[i]) vec_bytes[i] = 8'h00;
      pending_pixels.delete();
    end else begin
      if (pop && !empty) begin
        got_px = '{out_entry_index, out_book_select, out_pixel_pos, out_chan_y_plus_u,
                   out_chan_y_minus_uv, out_chan_y_plus_v, out_last_pixel};
        if (pending_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel entry %0d pos %0d",
                                    got_px.entry, got_px.pos));
        end else begin
          exp_px = pending_pixels.pop_front();
          if (got_px !== exp_px) begin
            report_mismatch($sformatf(
              "got entry %h book %b pos %0d bgr %h/%h/%h last %b, want %h %b %0d %h/%h/%h %b",
              got_px.entry, got_px.book, got_px.pos, got_px.blue, got_px.green, got_px.red,
              got_px.last, exp_px.entry, exp_px.book, exp_px.pos, exp_px.blue,
              exp_px.green, exp_px.red, exp_px.last));
          end
          checked_cnt++;
        end
      end
      if (push && !full) begin
        if (in_atom_start || phase inside {PARSE_SIZE, PARSE_FULL, PARSE_MASK, PARSE_VEC})
          used_cnt++;
        parse_atom_byte(in_data_byte, in_atom_start);
      end
    end
    fail_total     <= mism_cnt;
    pending        <= pending_pixels.size();
    bytes_used     <= used_cnt;
    pixels_checked <= checked_cnt;
  end

endmodule

// ===== verif/tb_codebook_vector_expander_top.sv =====
module tb_codebook_vector_expander_top;
  timeunit 1ns;
  timeprecision 1ps;

  // The watchdog ends the run if this many cycles pass without any transaction.
  localparam int WATCHDOG_LIMIT = 2000;
  // Parsed bytes of random stimulus per idling phase.
  localparam int PHASE_BYTES    = 45;

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic [7:0] in_data_byte  = 8'h00;
  logic       in_atom_start = 1'b0;
  logic       push          = 1'b0;
  logic       pop           = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_entry_index;
  logic       out_book_select;
  logic [1:0] out_pixel_pos;
  logic [7:0] out_chan_y_plus_u;
  logic [7:0] out_chan_y_minus_uv;
  logic [7:0] out_chan_y_plus_v;
  logic       out_last_pixel;

  int fail_total;
  int pending;
  int bytes_used;
  int pixels_checked;

  // Percentages of cycles in which the sender holds back and the receiver stalls.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int atoms_sent    = 0;
  int idle_cycles   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  codebook_vector_expander_top i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_data_byte        (in_data_byte),
    .in_atom_start       (in_atom_start),
    .push                (push),
    .full                (full),
    .out_entry_index     (out_entry_index),
    .out_book_select     (out_book_select),
    .out_pixel_pos       (out_pixel_pos),
    .out_chan_y_plus_u   (out_chan_y_plus_u),
    .out_chan_y_minus_uv (out_chan_y_minus_uv),
    .out_chan_y_plus_v   (out_chan_y_plus_v),
    .out_last_pixel      (out_last_pixel),
    .empty               (empty),
    .pop                 (pop)
  );

  // The checker watches both channels, predicts every pixel and compares.
  codebook_vector_expander_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_data_byte        (in_data_byte),
    .in_atom_start       (in_atom_start),
    .push                (push),
    .full                (full),
    .out_entry_index     (out_entry_index),
    .out_book_select     (out_book_select),
    .out_pixel_pos       (out_pixel_pos),
    .out_chan_y_plus_u   (out_chan_y_plus_u),
    .out_chan_y_minus_uv (out_chan_y_minus_uv),
    .out_chan_y_plus_v   (out_chan_y_plus_v),
    .out_last_pixel      (out_last_pixel),
    .empty               (empty),
    .pop                 (pop),
    .fail_total          (fail_total),
    .pending             (pending),
    .bytes_used          (bytes_used),
    .pixels_checked      (pixels_checked)
  );

  // The receiver decides afresh at every edge whether it takes a pixel, so its stalls
  // land on every phase of the pixel stream.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: a run that stops moving in either direction is a failure.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired after %0d cycles without a transaction.", idle_cycles);
        $display("codebook_vector_expander_top regression: fail");
        $finish;
      end
    end
  end

  // Biased toward the values that drive the clipping to both rails.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly sparse masks so that a complete walk of the book stays short; an all-ones
  // mask is only used when the walk is cut short anyway.
  function automatic logic [31:0] pick_mask(input logic dense_ok);
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return dense_ok ? 32'hFFFF_FFFF : 32'h0000_0000;
      2:       return 32'h8000_0001;
      default: return $urandom & $urandom & $urandom & $urandom;
    endcase
  endfunction

  // One input transaction. Push is driven at the edge and stays high until an edge
  // at which full is low; idle cycles are only inserted before a new byte.
  task automatic send_byte(input logic [7:0] d, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push          <= 1'b1;
    in_data_byte  <= d;
    in_atom_start <= first;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_header(input logic [7:0] atom_code, input logic [23:0] size);
    atoms_sent++;
    send_byte(atom_code, 1'b1);
    send_byte(size[23:16], 1'b0);
    send_byte(size[15:8], 1'b0);
    send_byte(size[7:0], 1'b0);
  endtask

  // Six bytes in stream order: Y0, Y1, Y2, Y3, U, V.
  task automatic send_vec(input logic [5:0][7:0] vb);
    int i;
    for (i = 5; i >= 0; i--) send_byte(vb[i], 1'b0);
  endtask

  task automatic send_rand_vecs(input int count);
    repeat (count * 6) send_byte(rand_byte(), 1'b0);
  endtask

  task automatic send_mask(input logic [31:0] m);
    send_byte(m[31:24], 1'b0);
    send_byte(m[23:16], 1'b0);
    send_byte(m[15:8], 1'b0);
    send_byte(m[7:0], 1'b0);
  endtask

  task automatic send_noise(input int count);
    repeat (count) send_byte(8'($urandom_range(255)), 1'b0);
  endtask

  // Random atoms until the given number of bytes has actually been parsed.
  task automatic run_random(input int target);
    int          start_cnt;
    int          sel;
    int          n;
    int          groups;
    int          budget;
    int          g;
    int          b;
    logic        walk_all;
    logic        cut;
    logic [7:0]  atom_code;
    logic [23:0] size;
    logic [31:0] m;
    start_cnt = bytes_used;
    while (bytes_used - start_cnt < target) begin
      sel = $urandom_range(99);
      if (sel < 40) begin
        // Full book: usually a well-formed size, sometimes a tiny or a huge one,
        // sometimes cut short by the next atom.
        atom_code = $urandom_range(1) ? cbve_pkg::TYPE_FULL_SMOOTH :
                                        cbve_pkg::TYPE_FULL_DETAIL;
        n         = $urandom_range(0, 5);
        case ($urandom_range(9))
          0:       size = 24'($urandom_range(0, 4));
          1:       size = 24'($urandom);
          default: size = 24'(4 + 6 * n + $urandom_range(0, 5));
        endcase
        send_header(atom_code, size);
        send_rand_vecs(($urandom_range(5) == 0) ? $urandom_range(0, n) : n);
        send_noise($urandom_range(0, 3));
      end else if (sel < 70) begin
        // Partial book: a few walk all entries, the rest stop after some vectors.
        atom_code = $urandom_range(1) ? cbve_pkg::TYPE_PART_SMOOTH :
                                        cbve_pkg::TYPE_PART_DETAIL;
        size      = ($urandom_range(4) == 0) ? 24'd4 : 24'($urandom);
        walk_all  = ($urandom_range(5) == 0);
        groups    = walk_all ? 8 : $urandom_range(1, 2);
        budget    = walk_all ? cbve_pkg::BOOK_ENTRIES : $urandom_range(0, 6);
        cut       = 1'b0;
        send_header(atom_code, size);
        for (g = 0; g < groups && !cut; g++) begin
          m = pick_mask(!walk_all);
          send_mask(m);
          for (b = 31; b >= 0 && !cut; b--) begin
            if (m[b]) begin
              if (budget == 0) begin
                cut = 1'b1;
              end else begin
                send_rand_vecs(1);
                budget--;
              end
            end
          end
        end
        send_noise($urandom_range(0, 4));
      end else if (sel < 82) begin
        // An atom of a type that the block does not know.
        do begin
          atom_code = 8'($urandom_range(255));
        end while (atom_code >= cbve_pkg::TYPE_FULL_DETAIL &&
                   atom_code <= cbve_pkg::TYPE_PART_SMOOTH);
        send_header(atom_code, 24'($urandom));
        send_noise($urandom_range(0, 8));
      end else begin
        send_noise($urandom_range(1, 4));
      end
    end
  endtask

  initial begin
    int send_idle_tab [4];
    int stall_tab [4];
    int ph;
    send_idle_tab = '{0, 76, 0, 18};
    stall_tab     = '{0, 0, 76, 18};

    // Reset is held at the start and never asserted again.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed atoms, with no idling on either side.
    // Bytes before any atom header are ignored.
    send_noise(2);
    // One detail vector whose chroma clips blue low on every pixel and red and green high on the bright ones.
    send_header(cbve_pkg::TYPE_FULL_DETAIL, 24'd10);
    send_vec({8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F});
    // A smooth book whose size does not divide evenly, so two vectors fit; the two
    // bytes after the end of the book are ignored.
    send_header(cbve_pkg::TYPE_FULL_SMOOTH, 24'd17);
    send_vec({8'hFF, 8'h00, 8'h80, 8'h01, 8'h7F, 8'h80});
    send_vec({8'h00, 8'h01, 8'hFE, 8'hFF, 8'h00, 8'h00});
    send_noise(2);
    // A type that is not a codebook makes the whole atom ignored.
    send_header(8'h24, 24'd10);
    send_noise(6);
    // Size four is an empty book, and so is a full book below four.
    send_header(cbve_pkg::TYPE_FULL_DETAIL, 24'd4);
    send_noise(6);
    send_header(cbve_pkg::TYPE_FULL_SMOOTH, 24'd3);
    send_noise(6);
    send_header(cbve_pkg::TYPE_PART_DETAIL, 24'd4);
    send_mask(32'hFFFF_FFFF);
    // A partial book ignores any other size and walks all entries, including the
    // first and the last entry of the book.
    send_header(cbve_pkg::TYPE_PART_SMOOTH, 24'h12_3456);
    send_mask(32'h8000_0001);
    send_rand_vecs(2);
    repeat (6) send_mask(32'h0000_0000);
    send_mask(32'h0000_0001);
    send_rand_vecs(1);
    send_noise(3);
    // A new header in the middle of a vector abandons the current atom.
    send_header(cbve_pkg::TYPE_FULL_DETAIL, 24'd1000);
    send_rand_vecs(1);
    send_noise(3);
    send_header(cbve_pkg::TYPE_PART_DETAIL, 24'd0);
    send_mask(32'hFFFF_FFFF);
    send_rand_vecs(2);
    send_noise(2);

    // Random atoms under each idling mix in turn.
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_idle_tab[ph];
      stall_pct     = stall_tab[ph];
      run_random(PHASE_BYTES);
    end

    // Drain: stop sending, let the receiver take everything, then allow a few more
    // cycles for any pixel that should not be there.
    push          <= 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d atom headers; %0d bytes were parsed and %0d pixels checked.",
             atoms_sent, bytes_used, pixels_checked);
    $display("Idling mixes: none, sender 76%%, receiver 76%%, both 18%%; %0d mismatches.",
             fail_total);
    if (fail_total == 0) begin
      $display("codebook_vector_expander_top regression: pass");
    end else begin
      $display("codebook_vector_expander_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/cbve_pkg.sv
hw/rtl/cbve_front.sv
hw/rtl/cbve_fifo.sv
hw/rtl/cbve_back.sv
hw/rtl/codebook_vector_expander_top.sv
verif/codebook_vector_expander_checker.sv
verif/tb_codebook_vector_expander_top.sv
